[hdl/dfm_pkg.sv]
// dfm_pkg: shared types and constants for the detector fault monitor.
// Used by dfm_lane, dfm_merge and detector_fault_monitor. No dependencies.
`default_nettype none

package dfm_pkg;

  // Counter and limit widths
  localparam int CNT_W   = 16;
  localparam int LIMIT_W = 8;
  localparam int PRESC_W = 6;
  localparam int MAX_DET = 8;

  localparam logic [CNT_W-1:0]   CNT_SAT      = 16'hffff;
  localparam logic [CNT_W-1:0]   MINUTE_TICKS = 16'd60;
  localparam logic [PRESC_W-1:0] PRESC_LAST   = 6'd59;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IDLE_LIMITS     = 2'd0,
    CFG_PRESENCE_LIMITS = 2'd1,
    CFG_ERRATIC_LIMITS  = 2'd2
  } cfg_idx_t;

  // Fault bits of one detector
  typedef struct packed {
    logic err;
    logic pres;
    logic idle;
  } lane_faults_t;

endpackage : dfm_pkg

`default_nettype wire

[hdl/dfm_lane.sv]
// dfm_lane: per-detector counters and fault evaluation for one detector.
// Depends on dfm_pkg.
`default_nettype none

module dfm_lane
  import dfm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               tick,
  input  wire logic               minute,
  input  wire logic               active,
  input  wire logic               erratic,
  input  wire logic [LIMIT_W-1:0] idle_lim,
  input  wire logic [LIMIT_W-1:0] pres_lim,
  input  wire logic [LIMIT_W-1:0] err_lim,
  output lane_faults_t            faults_nxt
);

  logic [CNT_W-1:0] active_cnt_r, active_cnt_nxt;
  logic [CNT_W-1:0] idle_cnt_r, idle_cnt_nxt;
  logic [CNT_W-1:0] err_cnt_r, err_cnt_upd, err_cnt_nxt;
  lane_faults_t     faults_r;
  logic [CNT_W-1:0] idle_thr, pres_thr;

  // Saturating second and event counters
  always_comb begin
    active_cnt_nxt = active_cnt_r;
    idle_cnt_nxt   = idle_cnt_r;
    if (active) begin
      if (active_cnt_r != CNT_SAT) active_cnt_nxt = active_cnt_r + 1'b1;
    end else begin
      if (idle_cnt_r != CNT_SAT) idle_cnt_nxt = idle_cnt_r + 1'b1;
    end
    err_cnt_upd = err_cnt_r;
    if (erratic && (err_cnt_r != CNT_SAT)) err_cnt_upd = err_cnt_r + 1'b1;
    err_cnt_nxt = minute ? '0 : err_cnt_upd;
  end

  // Limits in minutes scaled to seconds (max 15300, fits the counter width)
  assign idle_thr = CNT_W'(idle_lim) * MINUTE_TICKS;
  assign pres_thr = CNT_W'(pres_lim) * MINUTE_TICKS;

  // Minute evaluation on the updated counts; zero limit holds the bit
  always_comb begin
    faults_nxt = faults_r;
    if (minute) begin
      if (idle_lim != '0) faults_nxt.idle = (idle_cnt_nxt >= idle_thr);
      if (pres_lim != '0) faults_nxt.pres = (active_cnt_nxt >= pres_thr);
      if (err_lim != '0)  faults_nxt.err  = (err_cnt_upd > CNT_W'(err_lim));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cnt_r <= '0;
      idle_cnt_r   <= '0;
      err_cnt_r    <= '0;
      faults_r     <= '0;
    end else if (tick) begin
      active_cnt_r <= active_cnt_nxt;
      idle_cnt_r   <= idle_cnt_nxt;
      err_cnt_r    <= err_cnt_nxt;
      faults_r     <= faults_nxt;
    end
  end

endmodule : dfm_lane

`default_nettype wire

[hdl/dfm_merge.sv]
// dfm_merge: gathers lane fault bits into per-kind vectors and holds the
// result in the output register. Depends on dfm_pkg.
`default_nettype none

module dfm_merge
  import dfm_pkg::*;
#(
  parameter int DETECTORS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire logic                out_stall,
  input  wire lane_faults_t        lane_faults [DETECTORS],
  input  wire logic                door,
  input  wire logic                minute,
  output logic                     out_valid,
  output logic [MAX_DET-1:0]       idle_faults,
  output logic [MAX_DET-1:0]       presence_faults,
  output logic [MAX_DET-1:0]       erratic_faults,
  output logic                     door_alarm,
  output logic                     minute_done
);

  logic               valid_r, valid_nxt;
  logic [MAX_DET-1:0] idle_v, pres_v, err_v;
  logic [MAX_DET-1:0] idle_r, pres_r, err_r;
  logic               door_r, minute_r;

  // Pack lane results; detectors beyond DETECTORS read as zero
  always_comb begin
    idle_v = '0;
    pres_v = '0;
    err_v  = '0;
    for (int k = 0; k < DETECTORS; k++) begin
      idle_v[k] = lane_faults[k].idle;
      pres_v[k] = lane_faults[k].pres;
      err_v[k]  = lane_faults[k].err;
    end
  end

  // Output register: loaded on input transfer, held while stalled
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idle_r   <= idle_v;
      pres_r   <= pres_v;
      err_r    <= err_v;
      door_r   <= door;
      minute_r <= minute;
    end
  end

  assign out_valid       = valid_r;
  assign idle_faults     = idle_r;
  assign presence_faults = pres_r;
  assign erratic_faults  = err_r;
  assign door_alarm      = door_r;
  assign minute_done     = minute_r;

endmodule : dfm_merge

`default_nettype wire

[hdl/detector_fault_monitor.sv]
// detector_fault_monitor: top level, limit registers, minute prescaler,
// one dfm_lane per detector and the dfm_merge output stage. Depends on dfm_pkg.
//
//   channel   handshake               payload
//   in_       in_valid / in_stall     active_bits, erratic_pulses, door_change
//   out_      out_valid / out_stall   idle/presence/erratic_faults, door_alarm,
//                                     minute_done
//   cfg_      cfg_valid / cfg_ready   cfg_index (2b), cfg_data (64b)
//
// One tick is accepted per cycle while in_stall is low; its result appears in the
// output register on the next cycle (lane update combinational, registered in merge).
// in_stall is high only while a result waits and out_stall is high.
// Synchronous active-low reset clears counters, fault bits, limits, prescaler.
// cfg_ready is always high.
`default_nettype none

module detector_fault_monitor
  import dfm_pkg::*;
#(
  parameter int DETECTORS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // tick input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [MAX_DET-1:0] in_active_bits,
  input  wire logic [MAX_DET-1:0] in_erratic_pulses,
  input  wire logic               in_door_change,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [MAX_DET-1:0]      out_idle_faults,
  output logic [MAX_DET-1:0]      out_presence_faults,
  output logic [MAX_DET-1:0]      out_erratic_faults,
  output logic                    out_door_alarm,
  output logic                    out_minute_done,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [63:0]        idle_lim_r, pres_lim_r, err_lim_r;
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic               tick, minute;
  lane_faults_t       lane_faults [DETECTORS];

  // Input transfer
  assign in_stall = out_valid & out_stall;
  assign tick     = in_valid & ~in_stall;

  // Limit registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_lim_r <= '0;
      pres_lim_r <= '0;
      err_lim_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IDLE_LIMITS:     idle_lim_r <= cfg_data;
        CFG_PRESENCE_LIMITS: pres_lim_r <= cfg_data;
        CFG_ERRATIC_LIMITS:  err_lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Seconds-to-minute prescaler, counts 0..59
  assign minute    = (presc_r == PRESC_LAST);
  assign presc_nxt = minute ? '0 : presc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= '0;
    end else if (tick) begin
      presc_r <= presc_nxt;
    end
  end

  // One lane per detector
  for (genvar k = 0; k < DETECTORS; k++) begin : g_lane
    dfm_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .tick       (tick),
      .minute     (minute),
      .active     (in_active_bits[k]),
      .erratic    (in_erratic_pulses[k]),
      .idle_lim   (idle_lim_r[k*LIMIT_W +: LIMIT_W]),
      .pres_lim   (pres_lim_r[k*LIMIT_W +: LIMIT_W]),
      .err_lim    (err_lim_r[k*LIMIT_W +: LIMIT_W]),
      .faults_nxt (lane_faults[k])
    );
  end

  // Merge and output register
  dfm_merge #(
    .DETECTORS (DETECTORS)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (tick),
    .out_stall       (out_stall),
    .lane_faults     (lane_faults),
    .door            (in_door_change),
    .minute          (minute),
    .out_valid       (out_valid),
    .idle_faults     (out_idle_faults),
    .presence_faults (out_presence_faults),
    .erratic_faults  (out_erratic_faults),
    .door_alarm      (out_door_alarm),
    .minute_done     (out_minute_done)
  );

endmodule : detector_fault_monitor

`default_nettype wire
